// ===== hw/rtl/hs_pkg.sv =====
// heap sort package: datapath constants, microcode word and control program
package hs_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int VAL_W       = 32;
   localparam int STEP_W      = 5;
   localparam int ACT_W       = 4;
   localparam int COND_W      = 4;

   // datapath actions
   localparam logic [ACT_W-1:0] ACT_IDLE      = 4'd0;
   localparam logic [ACT_W-1:0] ACT_NOP       = 4'd1;
   localparam logic [ACT_W-1:0] ACT_BLD_START = 4'd2;
   localparam logic [ACT_W-1:0] ACT_LOAD_CUR  = 4'd3;
   localparam logic [ACT_W-1:0] ACT_RD_L      = 4'd4;
   localparam logic [ACT_W-1:0] ACT_RD_R      = 4'd5;
   localparam logic [ACT_W-1:0] ACT_PICK      = 4'd6;
   localparam logic [ACT_W-1:0] ACT_MOVE      = 4'd7;
   localparam logic [ACT_W-1:0] ACT_PUT       = 4'd8;
   localparam logic [ACT_W-1:0] ACT_RD_LAST   = 4'd9;
   localparam logic [ACT_W-1:0] ACT_RD_ROOT   = 4'd10;
   localparam logic [ACT_W-1:0] ACT_SWAP      = 4'd11;
   localparam logic [ACT_W-1:0] ACT_O_RD      = 4'd12;
   localparam logic [ACT_W-1:0] ACT_O_LOAD    = 4'd13;
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 4'd14;

   // jump conditions
   localparam logic [COND_W-1:0] COND_NEVER    = 4'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 4'd1;
   localparam logic [COND_W-1:0] COND_NO_START = 4'd2;
   localparam logic [COND_W-1:0] COND_BI_ZERO  = 4'd3;
   localparam logic [COND_W-1:0] COND_L_OUT    = 4'd4;
   localparam logic [COND_W-1:0] COND_NOT_GT   = 4'd5;
   localparam logic [COND_W-1:0] COND_BUILD    = 4'd6;
   localparam logic [COND_W-1:0] COND_HSZ_LE1  = 4'd7;
   localparam logic [COND_W-1:0] COND_OUT_BUSY = 4'd8;
   localparam logic [COND_W-1:0] COND_NOT_LAST = 4'd9;

   // program addresses
   localparam logic [STEP_W-1:0] ST_IDLE   = 5'd0;
   localparam logic [STEP_W-1:0] ST_BTEST  = 5'd1;
   localparam logic [STEP_W-1:0] ST_BSTART = 5'd2;
   localparam logic [STEP_W-1:0] ST_BLOAD  = 5'd3;
   localparam logic [STEP_W-1:0] ST_S0     = 5'd4;
   localparam logic [STEP_W-1:0] ST_S1     = 5'd5;
   localparam logic [STEP_W-1:0] ST_S2     = 5'd6;
   localparam logic [STEP_W-1:0] ST_S3     = 5'd7;
   localparam logic [STEP_W-1:0] ST_S4     = 5'd8;
   localparam logic [STEP_W-1:0] ST_SEND   = 5'd9;
   localparam logic [STEP_W-1:0] ST_ETEST  = 5'd10;
   localparam logic [STEP_W-1:0] ST_E1     = 5'd11;
   localparam logic [STEP_W-1:0] ST_E2     = 5'd12;
   localparam logic [STEP_W-1:0] ST_E3     = 5'd13;
   localparam logic [STEP_W-1:0] ST_O0     = 5'd14;
   localparam logic [STEP_W-1:0] ST_O1     = 5'd15;
   localparam logic [STEP_W-1:0] ST_DONE   = 5'd16;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic start;
      logic bi_zero;
      logic l_out;
      logic gt;
      logic build;
      logic hsz_le1;
      logic out_busy;
      logic last_k;
   } flags_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         ST_IDLE:   w = '{ACT_IDLE,      COND_NO_START, ST_IDLE};
         ST_BTEST:  w = '{ACT_NOP,       COND_BI_ZERO,  ST_ETEST};
         ST_BSTART: w = '{ACT_BLD_START, COND_NEVER,    ST_IDLE};
         ST_BLOAD:  w = '{ACT_LOAD_CUR,  COND_ALWAYS,   ST_S0};
         ST_S0:     w = '{ACT_RD_L,      COND_L_OUT,    ST_SEND};
         ST_S1:     w = '{ACT_RD_R,      COND_NEVER,    ST_IDLE};
         ST_S2:     w = '{ACT_PICK,      COND_NEVER,    ST_IDLE};
         ST_S3:     w = '{ACT_NOP,       COND_NOT_GT,   ST_SEND};
         ST_S4:     w = '{ACT_MOVE,      COND_ALWAYS,   ST_S0};
         ST_SEND:   w = '{ACT_PUT,       COND_BUILD,    ST_BTEST};
         ST_ETEST:  w = '{ACT_NOP,       COND_HSZ_LE1,  ST_O0};
         ST_E1:     w = '{ACT_RD_LAST,   COND_NEVER,    ST_IDLE};
         ST_E2:     w = '{ACT_RD_ROOT,   COND_NEVER,    ST_IDLE};
         ST_E3:     w = '{ACT_SWAP,      COND_ALWAYS,   ST_S0};
         ST_O0:     w = '{ACT_O_RD,      COND_OUT_BUSY, ST_O0};
         ST_O1:     w = '{ACT_O_LOAD,    COND_NOT_LAST, ST_O0};
         ST_DONE:   w = '{ACT_CLEAR,     COND_ALWAYS,   ST_IDLE};
         default:   w = '{ACT_NOP,       COND_ALWAYS,   ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/hs_ram.sv =====
// generic single write port ram with registered read
module hs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/hs_seq.sv =====
// heap sort microcode sequencer: step counter, control rom and jump logic
module hs_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  hs_pkg::flags_type        flags,
   output logic [hs_pkg::ACT_W-1:0] act
);
   import hs_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_type         word;
   logic              jump;

   assign word = ucode_rom(step_ff);

   always_comb begin
      case (word.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_START: jump = !flags.start;
         COND_BI_ZERO:  jump = flags.bi_zero;
         COND_L_OUT:    jump = flags.l_out;
         COND_NOT_GT:   jump = !flags.gt;
         COND_BUILD:    jump = flags.build;
         COND_HSZ_LE1:  jump = flags.hsz_le1;
         COND_OUT_BUSY: jump = flags.out_busy;
         COND_NOT_LAST: jump = !flags.last_k;
         default:       jump = 1'b1;
      endcase
      step_in = jump ? word.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign act = word.act;

endmodule

// ===== hw/rtl/heap_sort.sv =====
// heap sort top level: load port, heap datapath and result register
//
// usage
// - requests arrive on req_valid/req_ready with req_value_in (signed) and req_last_in
// - values are stored in arrival order, at most 64 per set; extra values are dropped
// - a request with req_last_in set starts the sort of the held set
// - req_ready is high only while the block is idle (one request per cycle then)
// - the sort builds a max-heap and extracts roots; each sift level runs two registered reads,
//   a pick, a compare and a move
// - results leave on rsp_valid/rsp_ready in ascending order, each read from the store and
//   then loaded into the result register, the largest flagged by rsp_last_out
// - a stalled receiver holds the sequencer in its output step; nothing is lost
// - the last result may still wait in the output register while a new set loads
// - reset empties the set and the result register; store contents stay undefined
module heap_sort (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [hs_pkg::VAL_W-1:0] req_value_in,
   input  logic                            req_last_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [hs_pkg::VAL_W-1:0] rsp_value_out,
   output logic                            rsp_last_out
);
   import hs_pkg::*;

   logic [ACT_W-1:0] act;
   flags_type        flags;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  hsz_ff, hsz_in;
   logic [CNT_W-1:0]  bi_ff, bi_in;
   logic [ADDR_W-1:0] node_ff, node_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0]  big_ff, big_in;
   logic              mode_ff, mode_in;
   logic signed [VAL_W-1:0] cur_ff, cur_in;
   logic signed [VAL_W-1:0] lv_ff, lv_in;
   logic signed [VAL_W-1:0] bv_ff, bv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [VAL_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [VAL_W-1:0]  ram_rdata;
   logic signed [VAL_W-1:0] rd_val;

   logic [CNT_W-1:0]  lidx;
   logic [CNT_W-1:0]  ridx;
   logic [CNT_W-1:0]  hsz_m1;
   logic [CNT_W-1:0]  bi_m1;
   logic              room;

   assign rd_val = $signed(ram_rdata);
   assign lidx   = {node_ff, 1'b1};
   assign ridx   = lidx + CNT_W'(1);
   assign hsz_m1 = hsz_ff - CNT_W'(1);
   assign bi_m1  = bi_ff - CNT_W'(1);
   assign room   = cnt_ff < CNT_W'(MAX_ITEMS);

   assign req_ready = (act == ACT_IDLE);

   assign flags.start    = req_valid && req_last_in;
   assign flags.bi_zero  = (bi_ff == '0);
   assign flags.l_out    = (lidx >= hsz_ff);
   assign flags.gt       = (bv_ff > cur_ff);
   assign flags.build    = mode_ff;
   assign flags.hsz_le1  = (hsz_ff <= CNT_W'(1));
   assign flags.out_busy = rsp_valid_ff && !rsp_ready;
   assign flags.last_k   = ({1'b0, k_ff} == (cnt_ff - CNT_W'(1)));

   hs_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .act   (act)
   );

   hs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      cnt_in       = cnt_ff;
      hsz_in       = hsz_ff;
      bi_in        = bi_ff;
      node_in      = node_ff;
      k_in         = k_ff;
      big_in       = big_ff;
      mode_in      = mode_ff;
      cur_in       = cur_ff;
      lv_in        = lv_ff;
      bv_in        = bv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;
      unique case (act)
         ACT_IDLE: begin
            if (req_valid) begin
               if (room) begin
                  ram_we    = 1'b1;
                  ram_waddr = cnt_ff[ADDR_W-1:0];
                  ram_wdata = req_value_in;
                  cnt_in    = cnt_ff + CNT_W'(1);
               end
               if (req_last_in) begin
                  hsz_in  = cnt_in;
                  bi_in   = cnt_in >> 1;
                  mode_in = 1'b1;
               end
            end
         end
         ACT_NOP: begin
         end
         ACT_BLD_START: begin
            bi_in     = bi_m1;
            node_in   = bi_m1[ADDR_W-1:0];
            ram_raddr = bi_m1[ADDR_W-1:0];
         end
         ACT_LOAD_CUR: begin
            cur_in = rd_val;
         end
         ACT_RD_L: begin
            ram_raddr = lidx[ADDR_W-1:0];
         end
         ACT_RD_R: begin
            lv_in     = rd_val;
            ram_raddr = ridx[ADDR_W-1:0];
         end
         ACT_PICK: begin
            if (ridx < hsz_ff && rd_val > lv_ff) begin
               big_in = ridx;
               bv_in  = rd_val;
            end else begin
               big_in = lidx;
               bv_in  = lv_ff;
            end
         end
         ACT_MOVE: begin
            ram_we    = 1'b1;
            ram_waddr = node_ff;
            ram_wdata = bv_ff;
            node_in   = big_ff[ADDR_W-1:0];
         end
         ACT_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = node_ff;
            ram_wdata = cur_ff;
         end
         ACT_RD_LAST: begin
            ram_raddr = hsz_m1[ADDR_W-1:0];
         end
         ACT_RD_ROOT: begin
            cur_in    = rd_val;
            ram_raddr = '0;
         end
         ACT_SWAP: begin
            ram_we    = 1'b1;
            ram_waddr = hsz_m1[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            hsz_in    = hsz_m1;
            node_in   = '0;
            mode_in   = 1'b0;
         end
         ACT_O_RD: begin
            ram_raddr = k_ff;
         end
         ACT_O_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_val;
            rsp_last_in  = flags.last_k;
            k_in         = k_ff + ADDR_W'(1);
         end
         ACT_CLEAR: begin
            cnt_in = '0;
            hsz_in = '0;
            k_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         hsz_ff       <= '0;
         k_ff         <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         hsz_ff       <= hsz_in;
         k_ff         <= k_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bi_ff        <= bi_in;
      node_ff      <= node_in;
      big_ff       <= big_in;
      cur_ff       <= cur_in;
      lv_ff        <= lv_in;
      bv_ff        <= bv_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_last_out  = rsp_last_ff;

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond capacity");

   a_heap_in_set: assert property (@(posedge clock) disable iff (reset)
      hsz_ff <= cnt_ff)
      else $error("heap size exceeds stored set");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      act == ACT_O_LOAD |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while stalled");

   a_move_range: assert property (@(posedge clock) disable iff (reset)
      act == ACT_MOVE |-> big_ff < hsz_ff)
      else $error("sift step moved outside the heap");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      $past(act == ACT_CLEAR) |-> (cnt_ff == '0 && hsz_ff == '0))
      else $error("set not cleared after output");

endmodule
